// ===== rtl/bsc_pkg.sv =====
// Shared types and constants for the barometer compensation block.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package bsc_pkg;

	localparam int PRESSURE_PER_TEMP = 3;
	localparam int PHASE_W = $clog2(PRESSURE_PER_TEMP + 1);

	localparam int RAW_W   = 24;
	localparam int COEFF_W = 16;
	localparam int IDX_W   = 3;
	localparam int PRES_W  = 17;
	localparam int TOUT_W  = 15;

	localparam int DT_W    = 25;
	localparam int TEMP_W  = 20;
	localparam int T2_W    = 18;
	localparam int WIDE_W  = 42;
	localparam int MUL_W   = 26;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int ACC_W   = 66;
	localparam int DIFF_W  = 46;
	localparam int SPLIT   = 20;

	localparam logic [IDX_W-1:0] REG_C1 = 3'd0;
	localparam logic [IDX_W-1:0] REG_C2 = 3'd1;
	localparam logic [IDX_W-1:0] REG_C3 = 3'd2;
	localparam logic [IDX_W-1:0] REG_C4 = 3'd3;
	localparam logic [IDX_W-1:0] REG_C5 = 3'd4;
	localparam logic [IDX_W-1:0] REG_C6 = 3'd5;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DT,
		OP_MT,
		OP_MS,
		OP_MO,
		OP_MT2,
		OP_MF,
		OP_MG,
		OP_GACC,
		OP_TFIN,
		OP_PLO,
		OP_PHI,
		OP_PSUM,
		OP_PDIF,
		OP_POUT
	} bsc_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DT,
		ST_MT,
		ST_MS,
		ST_MO,
		ST_MT2,
		ST_MF,
		ST_MG,
		ST_GACC,
		ST_TFIN,
		ST_PLO,
		ST_PHI,
		ST_PSUM,
		ST_PDIF,
		ST_POUT
	} bsc_state_t;

	typedef struct packed {
		bsc_op_t op;
	} bsc_cmd_t;

	typedef struct packed {
		logic out_free;
	} bsc_stat_t;

endpackage

// ===== rtl/bsc_ctrl.sv =====
// Sequencing controller for the barometer compensation block.
// Depends on bsc_pkg; drives datapath commands and the input stall.
module bsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bsc_pkg::bsc_stat_t  stat,
	output bsc_pkg::bsc_cmd_t   cmd
);

	bsc_pkg::bsc_state_t state_q, state_d;
	logic [bsc_pkg::PHASE_W-1:0] phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsc_pkg::ST_IDLE;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		cmd.op   = bsc_pkg::OP_NOP;
		in_stall = 1'b1;
		unique case (state_q)
			bsc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op = bsc_pkg::OP_LOAD;
					if (phase_q == '0) begin
						state_d = bsc_pkg::ST_DT;
					end else begin
						state_d = bsc_pkg::ST_PLO;
					end
					if (phase_q == bsc_pkg::PHASE_W'(bsc_pkg::PRESSURE_PER_TEMP)) begin
						phase_d = '0;
					end else begin
						phase_d = phase_q + 1'b1;
					end
				end
			end
			bsc_pkg::ST_DT: begin
				cmd.op = bsc_pkg::OP_DT;
				state_d = bsc_pkg::ST_MT;
			end
			bsc_pkg::ST_MT: begin
				cmd.op = bsc_pkg::OP_MT;
				state_d = bsc_pkg::ST_MS;
			end
			bsc_pkg::ST_MS: begin
				cmd.op = bsc_pkg::OP_MS;
				state_d = bsc_pkg::ST_MO;
			end
			bsc_pkg::ST_MO: begin
				cmd.op = bsc_pkg::OP_MO;
				state_d = bsc_pkg::ST_MT2;
			end
			bsc_pkg::ST_MT2: begin
				cmd.op = bsc_pkg::OP_MT2;
				state_d = bsc_pkg::ST_MF;
			end
			bsc_pkg::ST_MF: begin
				cmd.op = bsc_pkg::OP_MF;
				state_d = bsc_pkg::ST_MG;
			end
			bsc_pkg::ST_MG: begin
				cmd.op = bsc_pkg::OP_MG;
				state_d = bsc_pkg::ST_GACC;
			end
			bsc_pkg::ST_GACC: begin
				cmd.op = bsc_pkg::OP_GACC;
				state_d = bsc_pkg::ST_TFIN;
			end
			bsc_pkg::ST_TFIN: begin
				cmd.op = bsc_pkg::OP_TFIN;
				state_d = bsc_pkg::ST_IDLE;
			end
			bsc_pkg::ST_PLO: begin
				cmd.op = bsc_pkg::OP_PLO;
				state_d = bsc_pkg::ST_PHI;
			end
			bsc_pkg::ST_PHI: begin
				cmd.op = bsc_pkg::OP_PHI;
				state_d = bsc_pkg::ST_PSUM;
			end
			bsc_pkg::ST_PSUM: begin
				cmd.op = bsc_pkg::OP_PSUM;
				state_d = bsc_pkg::ST_PDIF;
			end
			bsc_pkg::ST_PDIF: begin
				cmd.op = bsc_pkg::OP_PDIF;
				state_d = bsc_pkg::ST_POUT;
			end
			bsc_pkg::ST_POUT: begin
				if (stat.out_free) begin
					cmd.op = bsc_pkg::OP_POUT;
					state_d = bsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/bsc_datapath.sv =====
// Datapath of the barometer compensation block: coefficients, shared multiplier,
// stored calibration state and output register. Depends on bsc_pkg.
module bsc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bsc_pkg::bsc_cmd_t                 cmd,
	output bsc_pkg::bsc_stat_t                stat,
	input  logic                              cfg_we,
	input  logic [bsc_pkg::IDX_W-1:0]         cfg_index,
	input  logic [bsc_pkg::COEFF_W-1:0]       cfg_data,
	input  logic [bsc_pkg::RAW_W-1:0]         raw_conversion,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bsc_pkg::PRES_W-1:0]        pressure_pa,
	output logic signed [bsc_pkg::TOUT_W-1:0] temperature_centideg
);

	logic [bsc_pkg::COEFF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic [bsc_pkg::RAW_W-1:0] raw_q;
	logic signed [bsc_pkg::DT_W-1:0] dt_q;
	logic signed [bsc_pkg::PROD_W-1:0] prod_q;
	logic signed [bsc_pkg::TEMP_W-1:0] temp_q;
	logic signed [bsc_pkg::WIDE_W-1:0] sens_q, off_q, sens2_q, off2_q;
	logic [bsc_pkg::T2_W-1:0] t2_q;
	logic signed [bsc_pkg::ACC_W-1:0] acc_q;
	logic signed [bsc_pkg::DIFF_W-1:0] diff_q;
	logic out_valid_q;
	logic [bsc_pkg::PRES_W-1:0] pres_q;
	logic signed [bsc_pkg::TOUT_W-1:0] tout_q;

	logic signed [bsc_pkg::MUL_W-1:0] mul_a, mul_b;
	logic signed [bsc_pkg::PROD_W-1:0] mul_p;
	logic signed [bsc_pkg::MUL_W-1:0] dt_ext, raw_ext, tdiff, tsum;
	logic signed [bsc_pkg::WIDE_W-1:0] pw, f5, g7, g11;
	logic signed [bsc_pkg::DIFF_W-1:0] p_full;
	logic [bsc_pkg::PRES_W-1:0] p_sat;
	logic signed [bsc_pkg::TOUT_W-1:0] t_sat;

	assign dt_ext  = bsc_pkg::MUL_W'(dt_q);
	assign raw_ext = $signed({2'b00, raw_q});
	assign tdiff   = bsc_pkg::MUL_W'(temp_q) - 26'sd2000;
	assign tsum    = bsc_pkg::MUL_W'(temp_q) + 26'sd1500;
	assign pw      = prod_q[bsc_pkg::WIDE_W-1:0];
	assign f5      = (pw <<< 2) + pw;
	assign g7      = (pw <<< 3) - pw;
	assign g11     = (pw <<< 3) + (pw <<< 1) + pw;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			bsc_pkg::OP_MT: begin
				mul_a = dt_ext;
				mul_b = $signed({10'd0, c6_q});
			end
			bsc_pkg::OP_MS: begin
				mul_a = dt_ext;
				mul_b = $signed({10'd0, c3_q});
			end
			bsc_pkg::OP_MO: begin
				mul_a = dt_ext;
				mul_b = $signed({10'd0, c4_q});
			end
			bsc_pkg::OP_MT2: begin
				mul_a = dt_ext;
				mul_b = dt_ext;
			end
			bsc_pkg::OP_MF: begin
				mul_a = tdiff;
				mul_b = tdiff;
			end
			bsc_pkg::OP_MG: begin
				mul_a = tsum;
				mul_b = tsum;
			end
			bsc_pkg::OP_PLO: begin
				mul_a = raw_ext;
				mul_b = $signed({6'd0, sens_q[bsc_pkg::SPLIT-1:0]});
			end
			bsc_pkg::OP_PHI: begin
				mul_a = raw_ext;
				mul_b = bsc_pkg::MUL_W'($signed(sens_q[bsc_pkg::WIDE_W-1:bsc_pkg::SPLIT]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign p_full = diff_q >>> 15;

	always_comb begin
		if (p_full < 0) begin
			p_sat = '0;
		end else if (p_full > 46'sd131071) begin
			p_sat = '1;
		end else begin
			p_sat = p_full[bsc_pkg::PRES_W-1:0];
		end
		if (temp_q < -20'sd8192) begin
			t_sat = -15'sd8192;
		end else if (temp_q > 20'sd16383) begin
			t_sat = 15'sd16383;
		end else begin
			t_sat = temp_q[bsc_pkg::TOUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsc_pkg::REG_C1: c1_q <= cfg_data;
				bsc_pkg::REG_C2: c2_q <= cfg_data;
				bsc_pkg::REG_C3: c3_q <= cfg_data;
				bsc_pkg::REG_C4: c4_q <= cfg_data;
				bsc_pkg::REG_C5: c5_q <= cfg_data;
				bsc_pkg::REG_C6: c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			sens_q <= '0;
			off_q  <= '0;
		end else begin
			case (cmd.op)
				bsc_pkg::OP_MS: begin
					temp_q <= bsc_pkg::TEMP_W'(prod_q >>> 23) + 20'sd2000;
				end
				bsc_pkg::OP_MO: begin
					sens_q <= bsc_pkg::WIDE_W'(prod_q >>> 8)
						+ $signed({11'd0, c1_q, 15'd0});
				end
				bsc_pkg::OP_MT2: begin
					off_q <= bsc_pkg::WIDE_W'(prod_q >>> 7)
						+ $signed({10'd0, c2_q, 16'd0});
				end
				bsc_pkg::OP_TFIN: begin
					if (temp_q < 20'sd2000) begin
						temp_q <= temp_q - $signed({2'b00, t2_q});
						off_q  <= off_q - off2_q;
						sens_q <= sens_q - sens2_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (cmd.op)
			bsc_pkg::OP_LOAD: raw_q <= raw_conversion;
			bsc_pkg::OP_DT: begin
				dt_q <= $signed({1'b0, raw_q}) - $signed({1'b0, c5_q, 8'd0});
			end
			bsc_pkg::OP_MF: t2_q <= prod_q[30+bsc_pkg::T2_W:31];
			bsc_pkg::OP_MG: begin
				off2_q  <= f5 >>> 1;
				sens2_q <= f5 >>> 2;
			end
			bsc_pkg::OP_GACC: begin
				if (temp_q < -20'sd1500) begin
					off2_q  <= off2_q + g7;
					sens2_q <= sens2_q + (g11 >>> 1);
				end
			end
			bsc_pkg::OP_PHI: acc_q <= bsc_pkg::ACC_W'(prod_q);
			bsc_pkg::OP_PSUM: begin
				acc_q <= (bsc_pkg::ACC_W'(prod_q) <<< bsc_pkg::SPLIT) + acc_q;
			end
			bsc_pkg::OP_PDIF: begin
				diff_q <= bsc_pkg::DIFF_W'(acc_q >>> 21) - bsc_pkg::DIFF_W'(off_q);
			end
			bsc_pkg::OP_POUT: begin
				pres_q <= p_sat;
				tout_q <= t_sat;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == bsc_pkg::OP_POUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free        = !out_valid_q || !out_stall;
	assign out_valid            = out_valid_q;
	assign pressure_pa          = pres_q;
	assign temperature_centideg = tout_q;

endmodule

// ===== rtl/baro_sensor_compensation_unit.sv =====
// Top level of the barometer compensation block; joins controller and datapath.
// Depends on bsc_pkg, bsc_ctrl and bsc_datapath.
//
// Raw conversions arrive in a fixed cycle: one temperature conversion, then
// three pressure conversions. The input is stalled until the previous
// conversion is finished. A temperature conversion produces no output; a
// pressure conversion yields one output transfer carrying pressure in pascals
// and the stored temperature in hundredths of a degree, both saturated. Both
// conversions are paced by the single 26 x 26 multiplier shared by all
// products, one product per cycle. A finished result waits in the output
// register while the next input is taken. Coefficients are written through the
// configuration channel, which is always ready; write only while idle.
module baro_sensor_compensation_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bsc_pkg::RAW_W-1:0]           raw_conversion,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bsc_pkg::PRES_W-1:0]          pressure_pa,
	output logic signed [bsc_pkg::TOUT_W-1:0]   temperature_centideg,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bsc_pkg::IDX_W-1:0]           cfg_index,
	input  logic [bsc_pkg::COEFF_W-1:0]         cfg_data
);

	bsc_pkg::bsc_cmd_t  cmd;
	bsc_pkg::bsc_stat_t stat;

	assign cfg_ready = 1'b1;

	bsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bsc_datapath u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.cfg_we               (cfg_valid && cfg_ready),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.raw_conversion       (raw_conversion),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.pressure_pa          (pressure_pa),
		.temperature_centideg (temperature_centideg)
	);

endmodule

// ===== rtl/bsc_checker.sv =====
// Port-level checker for the barometer compensation block, bound to the top level.
// Depends on bsc_pkg and baro_sensor_compensation_unit.
module bsc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [bsc_pkg::PRES_W-1:0]        pressure_pa,
	input logic signed [bsc_pkg::TOUT_W-1:0] temperature_centideg,
	input logic                              cfg_ready
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressure_pa)
			&& $stable(temperature_centideg))
		else $error("stalled result changed");

	// After an input transfer the input is stalled in the following cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");

	// Temperature never falls below its saturated lower limit while a result is valid.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_centideg >= -15'sd8192)
		else $error("temperature below saturation limit");

	// A new result is preceded by the input stall of its pressure conversion.
	a_out_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall, 1) && $past(in_stall, 4))
		else $error("result appeared too early");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind baro_sensor_compensation_unit bsc_checker u_bsc_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.in_valid             (in_valid),
	.in_stall             (in_stall),
	.out_valid            (out_valid),
	.out_stall            (out_stall),
	.pressure_pa          (pressure_pa),
	.temperature_centideg (temperature_centideg),
	.cfg_ready            (cfg_ready)
);
